// ===== hw/rtl/chbd_pkg.sv =====
// ----------------------------------------------------------------------------
// chbd_pkg
// Types, codes and helpers shared by the chunked body decoder modules.
// ----------------------------------------------------------------------------
package chbd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned SIZE_W   = 32;
    localparam int unsigned TOTAL_W  = 33;
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned PHASE_W  = 3;

    localparam logic [DIGIT_W-1:0] MAX_DIGITS = 4'd8;
    localparam logic [SIZE_W-1:0]  MAX_BODY_RESET = 32'd1048576;

    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_BUSY = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BIG  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              new_body;
    } in_item_t;

    typedef struct packed {
        logic                payload_valid;
        logic [BYTE_W-1:0]   payload_byte;
        logic [STATUS_W-1:0] status;
    } out_item_t;

    // hex digit decode: bit 4 set means the byte is not a hex digit
    function automatic logic [4:0] hex_value(input logic [BYTE_W-1:0] c);
        logic [4:0] v;
        begin
            v = 5'h10;
            if (c >= 8'h30 && c <= 8'h39) begin
                v = {1'b0, c[3:0]};
            end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
                v = {1'b0, c[3:0] + 4'd9};
            end
            return v;
        end
    endfunction

endpackage

// ===== hw/rtl/chbd_in_reg.sv =====
// ----------------------------------------------------------------------------
// chbd_in_reg
// Input register: holds one request until the core step consumes it.
// ----------------------------------------------------------------------------
module chbd_in_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  chbd_pkg::in_item_t s_item,
    input  logic               advance,
    output logic               in_vld,
    output chbd_pkg::in_item_t in_item
);
    import chbd_pkg::*;

    logic     vld_reg;
    logic     vld_next;
    in_item_t item_reg;

    assign s_ready = !vld_reg || advance;

    always_comb begin
        vld_next = vld_reg;
        if (s_valid && s_ready) begin
            vld_next = 1'b1;
        end else if (advance) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign in_vld  = vld_reg;
    assign in_item = item_reg;

endmodule

// ===== hw/rtl/chbd_core.sv =====
// ----------------------------------------------------------------------------
// chbd_core
// Framing state and one-byte step: size line parse, data pass, CRLF checks.
// ----------------------------------------------------------------------------
module chbd_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [chbd_pkg::SIZE_W-1:0]   cfg_wdata,
    input  logic                          step,
    input  chbd_pkg::in_item_t            in_item,
    output chbd_pkg::out_item_t           result
);
    import chbd_pkg::*;

    localparam logic [PHASE_W-1:0] PH_SIZE    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SIZE_LF = 3'd1;
    localparam logic [PHASE_W-1:0] PH_DATA    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DATA_CR = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DATA_LF = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DONE    = 3'd5;
    localparam logic [PHASE_W-1:0] PH_BIG     = 3'd6;
    localparam logic [PHASE_W-1:0] PH_BAD     = 3'd7;

    logic [SIZE_W-1:0]  max_body_reg;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [SIZE_W-1:0]  remain_reg, remain_next;
    logic [DIGIT_W-1:0] digits_reg, digits_next;
    logic [TOTAL_W-1:0] total_reg, total_next;

    logic [PHASE_W-1:0] ph_eff;
    logic [SIZE_W-1:0]  remain_eff;
    logic [DIGIT_W-1:0] digits_eff;
    logic [TOTAL_W-1:0] total_eff;
    logic [TOTAL_W-1:0] total_inc;
    logic [SIZE_W-1:0]  remain_dec;
    logic [4:0]         hex;
    logic               pay_vld;
    logic [BYTE_W-1:0]  pay_byte;

    always_comb begin
        // new_body clears the state before this byte is looked at
        ph_eff     = in_item.new_body ? PH_SIZE : phase_reg;
        remain_eff = in_item.new_body ? '0 : remain_reg;
        digits_eff = in_item.new_body ? '0 : digits_reg;
        total_eff  = in_item.new_body ? '0 : total_reg;

        hex        = hex_value(in_item.data_byte);
        total_inc  = total_eff + TOTAL_W'(1);
        remain_dec = remain_eff - SIZE_W'(1);

        phase_next  = ph_eff;
        remain_next = remain_eff;
        digits_next = digits_eff;
        total_next  = total_eff;
        pay_vld     = 1'b0;
        pay_byte    = '0;

        case (ph_eff)
            PH_SIZE: begin
                if (!hex[4]) begin
                    if (digits_eff >= MAX_DIGITS) begin
                        phase_next = PH_BAD;
                    end else begin
                        remain_next = {remain_eff[SIZE_W-5:0], hex[3:0]};
                        digits_next = digits_eff + DIGIT_W'(1);
                    end
                end else if (in_item.data_byte == CH_CR && digits_eff != '0) begin
                    phase_next = PH_SIZE_LF;
                end else begin
                    phase_next = PH_BAD;
                end
            end
            PH_SIZE_LF: begin
                if (in_item.data_byte != CH_LF) begin
                    phase_next = PH_BAD;
                end else begin
                    digits_next = '0;
                    phase_next  = (remain_eff == '0) ? PH_DONE : PH_DATA;
                end
            end
            PH_DATA: begin
                if (total_inc > {1'b0, max_body_reg}) begin
                    phase_next = PH_BIG;
                end else begin
                    total_next  = total_inc;
                    pay_vld     = 1'b1;
                    pay_byte    = in_item.data_byte;
                    remain_next = remain_dec;
                    if (remain_dec == '0) begin
                        phase_next = PH_DATA_CR;
                    end
                end
            end
            PH_DATA_CR: begin
                phase_next = (in_item.data_byte == CH_CR) ? PH_DATA_LF : PH_BAD;
            end
            PH_DATA_LF: begin
                if (in_item.data_byte == CH_LF) begin
                    phase_next  = PH_SIZE;
                    remain_next = '0;
                    digits_next = '0;
                end else begin
                    phase_next = PH_BAD;
                end
            end
            default: begin
                // complete and error phases hold until new_body
            end
        endcase

        result.payload_valid = pay_vld;
        result.payload_byte  = pay_byte;
        case (phase_next)
            PH_DONE: result.status = ST_DONE;
            PH_BIG:  result.status = ST_BIG;
            PH_BAD:  result.status = ST_BAD;
            default: result.status = ST_BUSY;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_body_reg <= MAX_BODY_RESET;
            phase_reg    <= PH_SIZE;
            remain_reg   <= '0;
            digits_reg   <= '0;
            total_reg    <= '0;
        end else begin
            if (cfg_we) begin
                max_body_reg <= cfg_wdata;
            end
            if (step) begin
                phase_reg  <= phase_next;
                remain_reg <= remain_next;
                digits_reg <= digits_next;
                total_reg  <= total_next;
            end
        end
    end

endmodule

// ===== hw/rtl/chbd_out_reg.sv =====
// ----------------------------------------------------------------------------
// chbd_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module chbd_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_vld,
    input  chbd_pkg::out_item_t result,
    output logic                advance,
    output logic                m_valid,
    input  logic                m_ready,
    output chbd_pkg::out_item_t m_item
);
    import chbd_pkg::*;

    logic      vld_reg;
    logic      vld_next;
    out_item_t item_reg;

    // step the core when a byte waits and the slot is free or draining
    assign advance = in_vld && (!vld_reg || m_ready);

    always_comb begin
        vld_next = vld_reg;
        if (advance) begin
            vld_next = 1'b1;
        end else if (m_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            item_reg <= result;
        end
    end

    assign m_valid = vld_reg;
    assign m_item  = item_reg;

endmodule

// ===== hw/rtl/http_chunked_body_decoder_top.sv =====
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top
// Byte-serial decoder for an HTTP/1.1 chunked request body.
// ----------------------------------------------------------------------------
// Takes one raw body byte per request and returns exactly one result per
// byte: the payload byte when it belongs to a chunk, plus a status (in
// progress, complete, too large, malformed). A new byte is taken every
// cycle unless a byte is held behind a full result slot with m_ready low.
// The core steps a held byte once the result slot is free or draining, and
// the result register captures its result as it steps. The rate is set by
// the phase/counter update in the core. Completion and errors are sticky
// until a byte arrives with new_body set. The user writes max_body_size via
// cfg_we/cfg_wdata only while no request is in flight, not enforced by the block.
module http_chunked_body_decoder_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [chbd_pkg::SIZE_W-1:0] cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  chbd_pkg::in_item_t          s_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output chbd_pkg::out_item_t         m_item
);
    import chbd_pkg::*;

    logic      advance;
    logic      in_vld;
    in_item_t  in_item;
    out_item_t result;

    chbd_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .advance (advance),
        .in_vld  (in_vld),
        .in_item (in_item)
    );

    chbd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (advance),
        .in_item   (in_item),
        .result    (result)
    );

    chbd_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_vld  (in_vld),
        .result  (result),
        .advance (advance),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // payload only flows while the body is still in progress
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.payload_valid |-> m_item.status == ST_BUSY)
        else $error("payload byte with end status");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.payload_valid |-> m_item.payload_byte == '0)
        else $error("payload byte not zero when not valid");

    // backpressure on input only when a byte is stuck behind a full result slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_vld && m_valid && !m_ready)
        else $error("input stalled without downstream stall");

    // a sticky end status repeats unless the next byte restarts the body
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !in_item.new_body && m_valid && m_item.status != ST_BUSY
        && !(m_valid && !m_ready) |=> m_item.status == $past(m_item.status))
        else $error("end status not sticky");

endmodule

// ===== dv/http_chunked_body_decoder_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_checker
// Watches the request and result channels of the chunked body decoder, keeps
// its own byte-level decoder state, and checks each result in order.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_checker
    import chbd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata,
    input  logic              s_valid,
    input  logic              s_ready,
    input  in_item_t          s_item,
    input  logic              m_valid,
    input  logic              m_ready,
    input  out_item_t         m_item,
    output int                mismatches,
    output int                in_flight,
    output int                payload_count,
    output int                done_count,
    output int                big_count,
    output int                bad_count
);

    typedef enum logic [PHASE_W-1:0] {
        SIZE_LINE,
        SIZE_LF,
        CHUNK_DATA,
        DATA_CR,
        DATA_LF,
        BODY_DONE,
        TOO_BIG,
        MALFORMED
    } phase_e;

    logic [SIZE_W-1:0]  max_body;
    phase_e             phase;
    logic [SIZE_W-1:0]  chunk_left;
    logic [DIGIT_W-1:0] digit_count;
    logic [TOTAL_W-1:0] body_total;

    out_item_t expected_results[$];
    out_item_t predicted;
    out_item_t oldest;

    int n_fail;
    int n_payload;
    int n_done;
    int n_big;
    int n_bad;

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_nibble(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] folded;
        logic [BYTE_W-1:0] d;
        folded = c | 8'h20;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            return {1'b0, d[3:0]};
        end else if (folded >= 8'h61 && folded <= 8'h66) begin
            d = folded - 8'h57;
            return {1'b0, d[3:0]};
        end
        return 5'h10;
    endfunction

    function automatic logic [STATUS_W-1:0] status_for(input phase_e p);
        case (p)
            BODY_DONE: return ST_DONE;
            TOO_BIG:   return ST_BIG;
            MALFORMED: return ST_BAD;
            default:   return ST_BUSY;
        endcase
    endfunction

    task automatic clear_decoder();
        phase       = SIZE_LINE;
        chunk_left  = '0;
        digit_count = '0;
        body_total  = '0;
    endtask

    task automatic decode_byte(input in_item_t req, output out_item_t res);
        logic [4:0]         nib;
        logic [TOTAL_W-1:0] next_total;
        phase_e             was;
        if (req.new_body) begin
            clear_decoder();
        end
        was = phase;
        res = '0;
        case (phase)
            SIZE_LINE: begin
                nib = hex_nibble(req.data_byte);
                if (!nib[4]) begin
                    if (digit_count >= MAX_DIGITS) begin
                        phase = MALFORMED;
                    end else begin
                        chunk_left  = {chunk_left[SIZE_W-5:0], nib[3:0]};
                        digit_count = digit_count + 1'b1;
                    end
                end else if (req.data_byte == CH_CR && digit_count != 0) begin
                    phase = SIZE_LF;
                end else begin
                    phase = MALFORMED;
                end
            end
            SIZE_LF: begin
                if (req.data_byte != CH_LF) begin
                    phase = MALFORMED;
                end else begin
                    digit_count = '0;
                    phase = (chunk_left == 0) ? BODY_DONE : CHUNK_DATA;
                end
            end
            CHUNK_DATA: begin
                next_total = body_total + 1'b1;
                if (next_total > {1'b0, max_body}) begin
                    phase = TOO_BIG;
                end else begin
                    body_total        = next_total;
                    res.payload_valid = 1'b1;
                    res.payload_byte  = req.data_byte;
                    chunk_left        = chunk_left - 1'b1;
                    if (chunk_left == 0) begin
                        phase = DATA_CR;
                    end
                end
            end
            DATA_CR: begin
                phase = (req.data_byte == CH_CR) ? DATA_LF : MALFORMED;
            end
            DATA_LF: begin
                if (req.data_byte == CH_LF) begin
                    phase       = SIZE_LINE;
                    chunk_left  = '0;
                    digit_count = '0;
                end else begin
                    phase = MALFORMED;
                end
            end
            default: begin
            end
        endcase
        res.status = status_for(phase);
        if (phase != was) begin
            case (phase)
                BODY_DONE: n_done++;
                TOO_BIG:   n_big++;
                MALFORMED: n_bad++;
                default: begin
                end
            endcase
        end
        if (res.payload_valid) begin
            n_payload++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_decoder();
            max_body = MAX_BODY_RESET;
            expected_results.delete();
        end else begin
            if (cfg_we) begin
                max_body = cfg_wdata;
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10) begin
                        $display("%0t: result with nothing expected: valid=%0d byte=%02h status=%0d",
                                 $time, m_item.payload_valid, m_item.payload_byte,
                                 m_item.status);
                    end
                end else begin
                    oldest = expected_results.pop_front();
                    if (m_item.payload_valid !== oldest.payload_valid ||
                        m_item.payload_byte !== oldest.payload_byte ||
                        m_item.status !== oldest.status) begin
                        n_fail++;
                        if (n_fail <= 10) begin
                            $display("%0t: mismatch: expected valid=%0d byte=%02h status=%0d",
                                     $time, oldest.payload_valid, oldest.payload_byte,
                                     oldest.status);
                            $display("%0t:           actual valid=%0d byte=%02h status=%0d",
                                     $time, m_item.payload_valid, m_item.payload_byte,
                                     m_item.status);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                decode_byte(s_item, predicted);
                expected_results.push_back(predicted);
            end
        end
        mismatches    <= n_fail;
        in_flight     <= expected_results.size();
        payload_count <= n_payload;
        done_count    <= n_done;
        big_count     <= n_big;
        bad_count     <= n_bad;
    end

endmodule

// ===== dv/http_chunked_body_decoder_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top_test
// Drives chunked bodies, broken framing and noise into the decoder under
// several body size limits, with random gaps on both channels.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_top_test;
    import chbd_pkg::*;

    localparam int ITEM_TARGET   = 1500;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int N_LIMITS      = 7;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_we;
    logic [SIZE_W-1:0] cfg_wdata;
    logic              s_valid;
    logic              s_ready;
    in_item_t          s_item;
    logic              m_valid;
    logic              m_ready;
    out_item_t         m_item;

    int mismatches;
    int in_flight;
    int payload_count;
    int done_count;
    int big_count;
    int bad_count;

    int cycles;
    int n_items;
    int n_settings;
    bit quiet;

    logic [BYTE_W-1:0] body_bytes[$];
    logic [SIZE_W-1:0] size_limits[N_LIMITS];

    http_chunked_body_decoder_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    http_chunked_body_decoder_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_item        (s_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item        (m_item),
        .mismatches    (mismatches),
        .in_flight     (in_flight),
        .payload_count (payload_count),
        .done_count    (done_count),
        .big_count     (big_count),
        .bad_count     (bad_count)
    );

    always #1 aclk = ~aclk;

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("*** FAILED ***");
        $finish;
    end

    // mostly short gaps, a few long ones, none in quiet stretches
    function automatic int pick_gap();
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 10) begin
            return 8'h30 + n;
        end
        return (upper ? 8'h41 : 8'h61) + {4'h0, n} - 8'd10;
    endfunction

    initial begin
        m_ready = 1'b0;
        forever begin
            int stall;
            stall = pick_gap();
            if (stall > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic nb, input bit counted);
        int       gap;
        in_item_t req;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        req.data_byte = b;
        req.new_body  = nb;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_item  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (counted) begin
            n_items++;
        end
    endtask

    task automatic send_queue(input logic first_nb, input int nsend, input int count_upto);
        int j;
        for (j = 0; j < nsend; j++) begin
            send_byte(body_bytes[j], (j == 0) ? first_nb : 1'b0, j < count_upto);
        end
    endtask

    // hold requests until every expected result has come back
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (in_flight != 0) @(negedge aclk);
    endtask

    task automatic set_limit(input logic [SIZE_W-1:0] limit);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= limit;
        @(negedge aclk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic queue_text(input string txt);
        int i;
        for (i = 0; i < txt.len(); i++) begin
            body_bytes.push_back(txt[i]);
        end
    endtask

    task automatic queue_crlf();
        body_bytes.push_back(CH_CR);
        body_bytes.push_back(CH_LF);
    endtask

    // size line with random letter case and sometimes leading zeros
    task automatic put_size(input logic [SIZE_W-1:0] val);
        int         need;
        int         ndig;
        int         i;
        logic [3:0] nib;
        need = 1;
        for (i = 1; i < 8; i++) begin
            if (val[4*i +: 4] != 0) begin
                need = i + 1;
            end
        end
        ndig = need;
        if ($urandom_range(0, 3) == 0) begin
            ndig = $urandom_range(need, 8);
        end
        for (i = ndig - 1; i >= 0; i--) begin
            nib = val[4*i +: 4];
            body_bytes.push_back(hex_char(nib, 1'($urandom_range(0, 1))));
        end
        queue_crlf();
    endtask

    task automatic play_body();
        logic [SIZE_W-1:0] sz;
        int                nch;
        int                ndata;
        int                cut;
        int                nsend;
        int                i;
        bit                cut_short;
        logic              first_nb;
        body_bytes.delete();
        cut_short = 1'b0;
        nch = $urandom_range(0, 4);
        for (i = 0; i < nch && !cut_short; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                // huge chunk: only a few of its bytes, then the next body restarts
                sz = $urandom();
                if (sz == 0) begin
                    sz = 1;
                end
                put_size(sz);
                ndata = $urandom_range(0, 6);
                cut_short = 1'b1;
            end else begin
                sz = $urandom_range(1, 12);
                put_size(sz);
                ndata = sz;
            end
            repeat (ndata) body_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
            if (!cut_short) begin
                queue_crlf();
            end
        end
        if (!cut_short) begin
            put_size('0);
        end
        nsend = body_bytes.size();
        cut   = nsend;
        if ($urandom_range(0, 4) == 0) begin
            cut = $urandom_range(0, nsend - 1);
            body_bytes[cut] = BYTE_W'($urandom_range(0, 255));
            nsend = cut + 1 + $urandom_range(0, 3);
            if (nsend > body_bytes.size()) begin
                nsend = body_bytes.size();
            end
            cut = cut + 1;
        end else if (!cut_short && $urandom_range(0, 3) == 0) begin
            // bytes after the end of the body are ignored
            repeat ($urandom_range(1, 3)) body_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
        end
        first_nb = ($urandom_range(0, 19) != 0);
        send_queue(first_nb, nsend, cut);
    endtask

    initial begin
        int p;
        int base;
        int r;
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        s_valid    = 1'b0;
        s_item     = '0;
        quiet      = 1'b0;
        n_items    = 0;
        n_settings = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // one-byte chunk, zero-size end, then a byte ignored after completion
        body_bytes.delete();
        queue_text("1");
        queue_crlf();
        body_bytes.push_back(8'h00);
        queue_crlf();
        queue_text("0");
        queue_crlf();
        queue_text("Z");
        send_queue(1'b0, body_bytes.size(), body_bytes.size());
        // empty size line, then a byte while malformed
        body_bytes.delete();
        body_bytes.push_back(CH_CR);
        queue_text("5");
        send_queue(1'b1, body_bytes.size(), body_bytes.size());
        // non-hex byte on the size line
        body_bytes.delete();
        queue_text("g");
        send_queue(1'b1, body_bytes.size(), body_bytes.size());
        // eight digits in mixed case, then a ninth
        body_bytes.delete();
        queue_text("fFFFFFFF0");
        send_queue(1'b1, body_bytes.size(), body_bytes.size());
        // no LF after the size line
        body_bytes.delete();
        queue_text("1");
        body_bytes.push_back(CH_CR);
        queue_text("X");
        send_queue(1'b1, body_bytes.size(), body_bytes.size());
        // no CR after chunk data
        body_bytes.delete();
        queue_text("1");
        queue_crlf();
        body_bytes.push_back(8'hFF);
        queue_text("X");
        send_queue(1'b1, body_bytes.size(), body_bytes.size());
        // CR after chunk data but no LF
        body_bytes.delete();
        queue_text("1");
        queue_crlf();
        body_bytes.push_back(8'hFF);
        body_bytes.push_back(CH_CR);
        queue_text("X");
        send_queue(1'b1, body_bytes.size(), body_bytes.size());
        // too large with a zero limit, then with a limit of one
        set_limit('0);
        body_bytes.delete();
        queue_text("1");
        queue_crlf();
        queue_text("A");
        send_queue(1'b1, body_bytes.size(), body_bytes.size());
        set_limit(32'd1);
        body_bytes.delete();
        queue_text("2");
        queue_crlf();
        queue_text("AB");
        send_queue(1'b1, body_bytes.size(), body_bytes.size());

        size_limits[0] = 32'hFFFF_FFFF;
        size_limits[1] = '0;
        size_limits[2] = 32'd1;
        size_limits[3] = $urandom_range(5, 80);
        size_limits[4] = $urandom();
        size_limits[5] = MAX_BODY_RESET;
        size_limits[6] = $urandom_range(20, 200);
        base = n_items;
        for (p = 0; p < N_LIMITS; p++) begin
            set_limit(size_limits[p]);
            while (n_items < base + (p + 1) * ITEM_TARGET / N_LIMITS) begin
                quiet = ($urandom_range(0, 7) == 0);
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    repeat ($urandom_range(1, 8)) begin
                        send_byte(BYTE_W'($urandom_range(0, 255)),
                                  $urandom_range(0, 3) == 0, 1'b1);
                    end
                end else if (r < 10) begin
                    drain();
                end else begin
                    play_body();
                end
            end
        end
        quiet = 1'b0;

        drain();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        $display("run: %0d requests under %0d size limits (all-ones, zero, one, default, random)",
                 n_items, n_settings);
        $display("seen: %0d payload bytes; bodies complete %0d, too large %0d, malformed %0d",
                 payload_count, done_count, big_count, bad_count);
        if (mismatches == 0 && in_flight == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, in_flight);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
